// ----- hw/rtl/uft_pkg.sv -----
// uft_pkg: shared types and constants of the union-find table engine.
// Request and result beats, table word layout and the port bundle
// between the sequencer and the table storage. No dependencies.
package uft_pkg;

	localparam int ELEM_W   = 8;
	localparam int CNT_W    = 9;
	localparam int RANK_W   = 4;
	localparam int SIZE_W   = 9;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	// request codes
	localparam logic [1:0] REQ_FIND  = 2'd0;
	localparam logic [1:0] REQ_SAME  = 2'd1;
	localparam logic [1:0] REQ_SIZE  = 2'd2;
	localparam logic [1:0] REQ_UNION = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ELEM_W-1:0] elem_a;
		logic [ELEM_W-1:0] elem_b;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0] root_a;
		logic              same_set;
		logic [SIZE_W-1:0] size_a;
		logic [CNT_W-1:0]  set_count;
		logic              index_error;
	} rsp_t;

	// one table entry: rank and size only mean something at a root
	typedef struct packed {
		logic [ELEM_W-1:0] parent;
		logic [RANK_W-1:0] rank;
		logic [SIZE_W-1:0] size;
	} word_t;

	// sequencer to storage: one read and at most one write per cycle
	typedef struct packed {
		logic [ELEM_W-1:0] rd_addr;
		logic              wr_en;
		logic [ELEM_W-1:0] wr_addr;
		word_t             wr_word;
	} mem_req_t;

endpackage

// ----- hw/rtl/union_find_table_top.sv -----
// union_find_table_top: top level of the disjoint-set engine; holds the
// element-count register and joins the sequencer to the table storage.
// Depends on uft_pkg, uft_store and uft_ctrl.
//
// Usage: raise start with a request beat; it is taken when busy is low.
// One result beat follows on result, marked by done for one cycle; the
// receiver cannot stall and must take it then. A request with an index at
// or above the element count gives done in the next cycle with index_error
// set and never raises busy, so such beats can follow back to back.
// Otherwise a find reads each node of its parent chain up to the root, then
// writes each node on the path to point at the root. Find and size run
// one find, a same-set test or a union three, and a merging union adds the
// states S_LINK1, S_LINK2 and S_FETCH to link the roots. done comes in the
// cycle after the last find, with busy already low, so the next request can
// be taken there. Rank keeps chains at eight hops or less. The single table
// read port, with its registered read data, sets the pace of the walk.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
// element count; it is ready while the engine is idle and start is low, and
// a write makes every element its own set at once. Reset does the same with
// the count at the table size.
module union_find_table_top #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  uft_pkg::req_t             request,
	output uft_pkg::rsp_t             result,
	output logic                      done,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [uft_pkg::CNT_W-1:0] cfg_data
);

	localparam int DEPTH = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;
	localparam logic [uft_pkg::CNT_W-1:0] COUNT_RESET = uft_pkg::CNT_W'(DEPTH);

	logic [uft_pkg::CNT_W-1:0] count_q;
	logic [uft_pkg::CNT_W-1:0] cfg_count;
	logic                      cfg_write;
	uft_pkg::mem_req_t         mreq;
	uft_pkg::word_t            word;

	// no count write in the cycle a request is taken
	assign cfg_ready = !busy && !start;
	assign cfg_write = cfg_valid && cfg_ready;

	// element count written as zero means one; above MAX_ELEMENTS clamps
	always_comb begin
		if (cfg_data == '0) begin
			cfg_count = uft_pkg::CNT_W'(1);
		end else if (32'(cfg_data) > MAX_ELEMENTS) begin
			cfg_count = uft_pkg::CNT_W'(MAX_ELEMENTS);
		end else begin
			cfg_count = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_write) begin
			count_q <= cfg_count;
		end
	end

	uft_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_write),
		.mreq   (mreq),
		.word   (word)
	);

	uft_ctrl #(
		.COUNT_INIT (COUNT_RESET)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.count      (count_q),
		.init       (cfg_write),
		.init_count (cfg_count),
		.word       (word),
		.mreq       (mreq),
		.busy       (busy),
		.result     (result),
		.done       (done)
	);

endmodule

// ----- hw/rtl/uft_store.sv -----
// uft_store: table memory of the union-find engine with per-entry valid
// bits; an entry not yet written reads as its own root of size one.
// Depends on uft_pkg.
module uft_store #(
	parameter int DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  uft_pkg::mem_req_t mreq,
	output uft_pkg::word_t    word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	uft_pkg::word_t                    mem [DEPTH];
	logic [DEPTH-1:0]                  valid_q;
	logic                              rd_valid_q;
	uft_pkg::word_t                    rd_word_q;
	logic [uft_pkg::ELEM_W-1:0]        rd_addr_q;

	// memory array: write port and registered read port
	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr[AW-1:0]] <= mreq.wr_word;
		end
		rd_word_q <= mem[mreq.rd_addr[AW-1:0]];
		rd_addr_q <= mreq.rd_addr;
	end

	// valid bits; a clear makes every entry read as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[mreq.rd_addr[AW-1:0]];
			if (clear) begin
				valid_q <= '0;
			end else if (mreq.wr_en) begin
				valid_q[mreq.wr_addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	// unwritten entries: parent is self, rank zero, size one
	always_comb begin
		if (rd_valid_q) begin
			word = rd_word_q;
		end else begin
			word.parent = rd_addr_q;
			word.rank   = '0;
			word.size   = uft_pkg::SIZE_W'(1);
		end
	end

endmodule

// ----- hw/rtl/uft_ctrl.sv -----
// uft_ctrl: sequencer of the union-find engine. Walks parent chains one
// memory read per cycle, compresses paths, links roots by rank.
// Depends on uft_pkg; drives uft_store through a mem_req_t bundle.
module uft_ctrl #(
	parameter logic [uft_pkg::CNT_W-1:0] COUNT_INIT = 9'd256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  uft_pkg::req_t              request,
	input  logic [uft_pkg::CNT_W-1:0]  count,
	input  logic                       init,
	input  logic [uft_pkg::CNT_W-1:0]  init_count,
	input  uft_pkg::word_t             word,
	output uft_pkg::mem_req_t          mreq,
	output logic                       busy,
	output uft_pkg::rsp_t              result,
	output logic                       done
);

	typedef enum logic [2:0] {
		S_IDLE, S_WALK, S_PACK, S_LINK1, S_LINK2, S_FETCH
	} state_t;

	// which find is running: a before b, b, or the closing find of a
	typedef enum logic [1:0] {
		PH_A1, PH_B, PH_A2
	} phase_t;

	state_t                        state_q;
	phase_t                        phase_q;
	uft_pkg::req_t                 req_q;
	logic [uft_pkg::ELEM_W-1:0]    cur_q;
	logic [uft_pkg::ELEM_W-1:0]    start_q;
	logic [uft_pkg::ELEM_W-1:0]    root_q;
	uft_pkg::word_t                root_word_q;
	logic [uft_pkg::ELEM_W-1:0]    ra_q;
	uft_pkg::word_t                ra_word_q;
	logic [uft_pkg::ELEM_W-1:0]    rb_q;
	uft_pkg::word_t                rb_word_q;
	logic                          same_q;
	logic [uft_pkg::CNT_W-1:0]     sets_q;
	uft_pkg::rsp_t                 result_q;
	logic                          done_q;

	logic                          at_root;
	logic                          find_done;
	logic                          need_link;
	logic                          a_wins;
	logic                          uses_b;
	logic                          bad_idx;
	logic [uft_pkg::ELEM_W-1:0]    fr_root;
	uft_pkg::word_t                fr_word;
	logic [uft_pkg::ELEM_W-1:0]    next_start;
	logic [uft_pkg::SIZE_W-1:0]    size_sum;
	logic [uft_pkg::RANK_W-1:0]    rank_up;

	assign busy   = (state_q != S_IDLE);
	assign result = result_q;
	assign done   = done_q;

	// chain walk and link arithmetic
	always_comb begin
		at_root   = (word.parent == cur_q);
		fr_root   = (state_q == S_WALK) ? cur_q : root_q;
		fr_word   = (state_q == S_WALK) ? word : root_word_q;
		find_done = ((state_q == S_WALK) && at_root && (start_q == cur_q)) ||
			((state_q == S_PACK) && (word.parent == root_q));
		need_link = (req_q.req_type == uft_pkg::REQ_UNION) && (fr_root != ra_q);
		next_start = (phase_q == PH_A1) ? req_q.elem_b : req_q.elem_a;
		a_wins    = (ra_word_q.rank > rb_word_q.rank);
		size_sum  = uft_pkg::SIZE_W'(ra_word_q.size + rb_word_q.size);
		if ((ra_word_q.rank == rb_word_q.rank) && (rb_word_q.rank != uft_pkg::RANK_MAX)) begin
			rank_up = uft_pkg::RANK_W'(rb_word_q.rank + 4'd1);
		end else begin
			rank_up = rb_word_q.rank;
		end
		uses_b  = (request.req_type == uft_pkg::REQ_SAME) ||
			(request.req_type == uft_pkg::REQ_UNION);
		bad_idx = ({1'b0, request.elem_a} >= count) ||
			(uses_b && ({1'b0, request.elem_b} >= count));
	end

	// memory port: one read address and at most one write per cycle
	always_comb begin
		mreq         = '0;
		mreq.rd_addr = cur_q;
		unique case (state_q)
			S_IDLE: begin
				mreq.rd_addr = request.elem_a;
			end
			S_WALK: begin
				if (find_done) begin
					mreq.rd_addr = next_start;
				end else if (at_root) begin
					mreq.rd_addr = start_q;
				end else begin
					mreq.rd_addr = word.parent;
				end
			end
			S_PACK: begin
				mreq.wr_en          = 1'b1;
				mreq.wr_addr        = cur_q;
				mreq.wr_word.parent = root_q;
				mreq.wr_word.rank   = word.rank;
				mreq.wr_word.size   = word.size;
				mreq.rd_addr        = find_done ? next_start : word.parent;
			end
			S_LINK1: begin
				// loser root goes under the winner
				mreq.wr_en = 1'b1;
				if (a_wins) begin
					mreq.wr_addr        = rb_q;
					mreq.wr_word        = rb_word_q;
					mreq.wr_word.parent = ra_q;
				end else begin
					mreq.wr_addr        = ra_q;
					mreq.wr_word        = ra_word_q;
					mreq.wr_word.parent = rb_q;
				end
			end
			S_LINK2: begin
				// winner root takes the summed size; root b, winning a rank tie, also grows its rank, saturating
				mreq.wr_en = 1'b1;
				if (a_wins) begin
					mreq.wr_addr      = ra_q;
					mreq.wr_word      = ra_word_q;
					mreq.wr_word.size = size_sum;
				end else begin
					mreq.wr_addr      = rb_q;
					mreq.wr_word      = rb_word_q;
					mreq.wr_word.rank = rank_up;
					mreq.wr_word.size = size_sum;
				end
			end
			S_FETCH: begin
				mreq.rd_addr = cur_q;
			end
			default: begin
				mreq.rd_addr = cur_q;
			end
		endcase
	end

	// sequencer state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_A1;
			req_q       <= '0;
			cur_q       <= '0;
			start_q     <= '0;
			root_q      <= '0;
			root_word_q <= '0;
			ra_q        <= '0;
			ra_word_q   <= '0;
			rb_q        <= '0;
			rb_word_q   <= '0;
			same_q      <= 1'b0;
			sets_q      <= COUNT_INIT;
			result_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (init) begin
				sets_q <= init_count;
			end
			priority if (find_done) begin
				unique case (phase_q)
					PH_A1: begin
						ra_q      <= fr_root;
						ra_word_q <= fr_word;
						cur_q     <= req_q.elem_b;
						start_q   <= req_q.elem_b;
						phase_q   <= PH_B;
						state_q   <= S_WALK;
					end
					PH_B: begin
						rb_q      <= fr_root;
						rb_word_q <= fr_word;
						same_q    <= (fr_root == ra_q);
						cur_q     <= req_q.elem_a;
						start_q   <= req_q.elem_a;
						phase_q   <= PH_A2;
						if (need_link) begin
							sets_q  <= sets_q - 9'd1;
							state_q <= S_LINK1;
						end else begin
							state_q <= S_WALK;
						end
					end
					PH_A2: begin
						result_q.root_a      <= fr_root;
						result_q.same_set    <= same_q;
						result_q.size_a      <= fr_word.size;
						result_q.set_count   <= sets_q;
						result_q.index_error <= 1'b0;
						done_q               <= 1'b1;
						state_q              <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (start) begin
							if (bad_idx) begin
								result_q.root_a      <= '0;
								result_q.same_set    <= 1'b0;
								result_q.size_a      <= '0;
								result_q.set_count   <= sets_q;
								result_q.index_error <= 1'b1;
								done_q               <= 1'b1;
							end else begin
								req_q   <= request;
								cur_q   <= request.elem_a;
								start_q <= request.elem_a;
								same_q  <= 1'b0;
								phase_q <= uses_b ? PH_A1 : PH_A2;
								state_q <= S_WALK;
							end
						end
					end
					S_WALK: begin
						if (at_root) begin
							root_q      <= cur_q;
							root_word_q <= word;
							cur_q       <= start_q;
							state_q     <= S_PACK;
						end else begin
							cur_q <= word.parent;
						end
					end
					S_PACK: begin
						cur_q <= word.parent;
					end
					S_LINK1: begin
						state_q <= S_LINK2;
					end
					S_LINK2: begin
						state_q <= S_FETCH;
					end
					S_FETCH: begin
						state_q <= S_WALK;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// ----- hw/rtl/uft_checker.sv -----
// uft_checker: port-level checks of the union-find engine, bound to
// union_find_table_top. Depends on uft_pkg.
module uft_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input uft_pkg::rsp_t             result,
	input logic                      done
);

	// an accepted request is either finished next cycle or still running
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither busy nor done");

	// a result beat only appears once the engine is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	// leaving busy always delivers a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// index errors carry zeroed fields
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.index_error |->
			result.root_a == '0 && result.size_a == '0 && !result.same_set)
		else $error("index error with nonzero fields");

	// there is always at least one set
	a_sets_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.set_count != '0)
		else $error("set count of zero");

endmodule

bind union_find_table_top uft_checker u_uft_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.done   (done)
);

// ----- tb/sv/uft_checker.sv -----
// uft_scoreboard: scoreboard for the union-find table engine. Watches the request,
// result and element-count channels, keeps its own disjoint-set tables and
// compares every result beat field by field. Depends on uft_pkg.
`timescale 1ns / 1ps

module uft_scoreboard #(
	parameter int MAX_ELEMS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  uft_pkg::req_t             request,
	input  uft_pkg::rsp_t             result,
	input  logic                      done,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [uft_pkg::CNT_W-1:0] cfg_data,
	output int unsigned               mismatches,
	output int unsigned               outstanding
);

	localparam int RESET_COUNT = (MAX_ELEMS < 256) ? MAX_ELEMS : 256;

	typedef struct {
		uft_pkg::req_t cause;
		uft_pkg::rsp_t want;
	} owed_t;

	// shadow forest
	logic [uft_pkg::ELEM_W-1:0] up_link   [MAX_ELEMS];
	logic [uft_pkg::RANK_W-1:0] tree_rank [MAX_ELEMS];
	int unsigned                grp_size  [MAX_ELEMS];
	int unsigned                groups;
	int unsigned                live_count;

	owed_t owed_rsp[$];
	owed_t head;
	owed_t fresh;

	function automatic void clear_sets();
		for (int i = 0; i < MAX_ELEMS; i++) begin
			up_link[i]   = uft_pkg::ELEM_W'(i);
			tree_rank[i] = '0;
			grp_size[i]  = 1;
		end
		groups = live_count;
	endfunction

	// walk to the root, then point every node on the path straight at it
	function automatic logic [uft_pkg::ELEM_W-1:0] root_of(
		input logic [uft_pkg::ELEM_W-1:0] x);
		logic [uft_pkg::ELEM_W-1:0] r;
		logic [uft_pkg::ELEM_W-1:0] cur;
		logic [uft_pkg::ELEM_W-1:0] nxt;
		int steps;
		r = x;
		steps = 0;
		while (up_link[r] != r && steps < MAX_ELEMS) begin
			r = up_link[r];
			steps++;
		end
		cur = x;
		steps = 0;
		while (cur != r && steps < MAX_ELEMS) begin
			nxt = up_link[cur];
			up_link[cur] = r;
			cur = nxt;
			steps++;
		end
		return r;
	endfunction

	// apply one request to the shadow forest and return its result beat
	function automatic uft_pkg::rsp_t resolve(input uft_pkg::req_t q);
		uft_pkg::rsp_t r;
		logic [uft_pkg::ELEM_W-1:0] ra;
		logic [uft_pkg::ELEM_W-1:0] rb;
		logic pair;
		pair = (q.req_type == uft_pkg::REQ_SAME) || (q.req_type == uft_pkg::REQ_UNION);
		r = '0;
		r.set_count = uft_pkg::CNT_W'(groups);
		if (q.elem_a >= live_count || (pair && q.elem_b >= live_count)) begin
			r.index_error = 1'b1;
			return r;
		end
		if (pair) begin
			ra = root_of(q.elem_a);
			rb = root_of(q.elem_b);
			r.same_set = (ra == rb);
			if (q.req_type == uft_pkg::REQ_UNION && ra != rb) begin
				groups--;
				if (tree_rank[ra] > tree_rank[rb]) begin
					up_link[rb] = ra;
					grp_size[ra] += grp_size[rb];
				end else begin
					up_link[ra] = rb;
					grp_size[rb] += grp_size[ra];
					// rank tie: the second root grows, saturating
					if (tree_rank[ra] == tree_rank[rb] && tree_rank[rb] < uft_pkg::RANK_MAX)
						tree_rank[rb]++;
				end
			end
		end
		ra = root_of(q.elem_a);
		r.root_a    = ra;
		r.size_a    = uft_pkg::SIZE_W'(grp_size[ra]);
		r.set_count = uft_pkg::CNT_W'(groups);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count = RESET_COUNT;
			clear_sets();
			owed_rsp.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// result beat against the oldest prediction
			if (done) begin
				if (owed_rsp.size() == 0) begin
					flag_mismatch("result beat with nothing outstanding");
				end else begin
					head = owed_rsp.pop_front();
					if (result.root_a !== head.want.root_a)
						flag_mismatch($sformatf("root_a got %0d want %0d (op %0d a %0d b %0d)",
							result.root_a, head.want.root_a, head.cause.req_type,
							head.cause.elem_a, head.cause.elem_b));
					if (result.same_set !== head.want.same_set)
						flag_mismatch($sformatf("same_set got %0b want %0b (op %0d a %0d b %0d)",
							result.same_set, head.want.same_set, head.cause.req_type,
							head.cause.elem_a, head.cause.elem_b));
					if (result.size_a !== head.want.size_a)
						flag_mismatch($sformatf("size_a got %0d want %0d (op %0d a %0d b %0d)",
							result.size_a, head.want.size_a, head.cause.req_type,
							head.cause.elem_a, head.cause.elem_b));
					if (result.set_count !== head.want.set_count)
						flag_mismatch($sformatf("set_count got %0d want %0d (op %0d a %0d b %0d)",
							result.set_count, head.want.set_count, head.cause.req_type,
							head.cause.elem_a, head.cause.elem_b));
					if (result.index_error !== head.want.index_error)
						flag_mismatch($sformatf("index_error got %0b want %0b (op %0d a %0d b %0d)",
							result.index_error, head.want.index_error, head.cause.req_type,
							head.cause.elem_a, head.cause.elem_b));
				end
			end
			// element-count write: clamp and start over
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == 0)
					live_count = 1;
				else if (cfg_data > MAX_ELEMS)
					live_count = MAX_ELEMS;
				else
					live_count = 32'(cfg_data);
				clear_sets();
			end
			// request beat
			if (start && !busy) begin
				fresh.cause = request;
				fresh.want  = resolve(request);
				owed_rsp.insert(owed_rsp.size(), fresh);
			end
			outstanding = owed_rsp.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: testbench top for union_find_table_top. Drives directed and random
// request beats and element-count writes, gives the verdict from uft_scoreboard.
// Depends on uft_pkg, uft_scoreboard and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_ELEMS   = 256;
	localparam int STALL_LIMIT = 4000;
	localparam int BLOCK_ITEMS = 120;
	localparam int BLOCKS      = 14;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	uft_pkg::req_t             request;
	uft_pkg::rsp_t             result;
	logic                      done;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [uft_pkg::CNT_W-1:0] cfg_data;
	int unsigned               mismatches;
	int unsigned               outstanding;
	int unsigned               live_count;
	int unsigned               stall_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	union_find_table_top #(.MAX_ELEMENTS(MAX_ELEMS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.result    (result),
		.done      (done),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	uft_scoreboard #(.MAX_ELEMS(MAX_ELEMS)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result      (result),
		.done        (done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// watchdog: any beat on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic uft_pkg::req_t mk_req(input logic [1:0] op, input int a, input int b);
		uft_pkg::req_t q;
		q.req_type = op;
		q.elem_a   = uft_pkg::ELEM_W'(a);
		q.elem_b   = uft_pkg::ELEM_W'(b);
		return q;
	endfunction

	// mostly in range, now and then anything the field holds
	function automatic logic [uft_pkg::ELEM_W-1:0] pick_elem(input int unsigned n);
		if ($urandom_range(0, 9) == 0)
			return uft_pkg::ELEM_W'($urandom_range(0, 255));
		return uft_pkg::ELEM_W'($urandom_range(0, n - 1));
	endfunction

	// unions weighted up so trees grow deep
	function automatic uft_pkg::req_t random_req(input int unsigned n);
		uft_pkg::req_t q;
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			q.req_type = uft_pkg::REQ_UNION;
		else if (roll < 6)
			q.req_type = uft_pkg::REQ_SAME;
		else if (roll < 8)
			q.req_type = uft_pkg::REQ_FIND;
		else
			q.req_type = uft_pkg::REQ_SIZE;
		q.elem_a = pick_elem(n);
		q.elem_b = pick_elem(n);
		return q;
	endfunction

	// present one request beat after random idle cycles; returns at the edge that takes it
	task automatic present(input uft_pkg::req_t item, input int unsigned idle_pct);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		request <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every predicted result has arrived
	task automatic drain_all();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// element-count write; call only after drain_all
	task automatic write_count(input logic [uft_pkg::CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (value == 0)
			live_count = 1;
		else if (value > MAX_ELEMS)
			live_count = MAX_ELEMS;
		else
			live_count = 32'(value);
	endtask

	initial begin
		logic [uft_pkg::CNT_W-1:0] next_count;
		int unsigned               idle_pct;
		int                        peer;

		arst_n     <= 1'b0;
		start      <= 1'b0;
		request    <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		live_count = MAX_ELEMS;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: full table after reset, extremes and rank ties
		present(mk_req(uft_pkg::REQ_FIND, 0, 0), 0);
		present(mk_req(uft_pkg::REQ_FIND, 255, 0), 0);
		present(mk_req(uft_pkg::REQ_SIZE, 255, 255), 0);
		present(mk_req(uft_pkg::REQ_SAME, 0, 255), 0);
		present(mk_req(uft_pkg::REQ_UNION, 0, 255), 0);
		present(mk_req(uft_pkg::REQ_UNION, 255, 0), 0);
		present(mk_req(uft_pkg::REQ_SIZE, 0, 0), 0);
		present(mk_req(uft_pkg::REQ_UNION, 1, 2), 0);
		present(mk_req(uft_pkg::REQ_UNION, 1, 0), 0);
		present(mk_req(uft_pkg::REQ_FIND, 1, 0), 0);
		present(mk_req(uft_pkg::REQ_SAME, 2, 255), 0);
		present(mk_req(uft_pkg::REQ_UNION, 3, 3), 0);

		// directed: indices out of range, second index ignored by find
		drain_all();
		write_count(9'd5);
		present(mk_req(uft_pkg::REQ_UNION, 4, 5), 0);
		present(mk_req(uft_pkg::REQ_SAME, 5, 0), 0);
		present(mk_req(uft_pkg::REQ_FIND, 5, 0), 0);
		present(mk_req(uft_pkg::REQ_SIZE, 255, 0), 0);
		present(mk_req(uft_pkg::REQ_FIND, 4, 255), 0);

		// directed: count of zero clamps to one element
		drain_all();
		write_count(9'd0);
		present(mk_req(uft_pkg::REQ_FIND, 0, 0), 0);
		present(mk_req(uft_pkg::REQ_UNION, 0, 0), 0);
		present(mk_req(uft_pkg::REQ_SIZE, 0, 0), 0);
		present(mk_req(uft_pkg::REQ_FIND, 1, 0), 0);

		// directed: count above the maximum clamps to the maximum
		drain_all();
		write_count(9'd511);
		present(mk_req(uft_pkg::REQ_UNION, 0, 255), 0);
		present(mk_req(uft_pkg::REQ_SIZE, 255, 0), 0);

		// random blocks, each from a fresh element count
		for (int blk = 0; blk < BLOCKS; blk++) begin
			unique case (blk)
				0:       next_count = 9'd256;
				1:       next_count = 9'd1;
				2:       next_count = 9'd2;
				3:       next_count = 9'd3;
				4:       next_count = 9'd0;
				5:       next_count = 9'd511;
				6:       next_count = 9'd8;
				7:       next_count = 9'd16;
				8:       next_count = 9'd40;
				9:       next_count = 9'd100;
				10:      next_count = 9'd200;
				11:      next_count = 9'd256;
				12:      next_count = 9'd257;
				default: next_count = uft_pkg::CNT_W'($urandom_range(1, 511));
			endcase
			idle_pct = (blk < 5) ? 10 : (blk < 10) ? 62 : 0;
			drain_all();
			write_count(next_count);
			for (int k = 0; k < BLOCK_ITEMS; k++) begin
				if ($urandom_range(0, 99) == 0)
					drain_all();
				present(random_req(live_count), idle_pct);
			end
		end

		// merge everything into one set of the largest size
		drain_all();
		write_count(9'd256);
		for (int k = 1; k < MAX_ELEMS; k++) begin
			peer = $urandom_range(0, k - 1);
			if ($urandom_range(0, 1) == 1)
				present(mk_req(uft_pkg::REQ_UNION, k, peer), 0);
			else
				present(mk_req(uft_pkg::REQ_UNION, peer, k), 0);
			if ($urandom_range(0, 7) == 0)
				present(mk_req(uft_pkg::REQ_FIND, $urandom_range(0, k), 0), 0);
		end
		present(mk_req(uft_pkg::REQ_SIZE, 0, 0), 0);

		drain_all();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- union_find_table_top.f -----
hw/rtl/uft_pkg.sv
hw/rtl/uft_store.sv
hw/rtl/uft_ctrl.sv
hw/rtl/union_find_table_top.sv
hw/rtl/uft_checker.sv
tb/sv/uft_checker.sv
tb/sv/tb_top.sv
